// ----- design/lorentzian_peak_product_top_macros.svh -----
`ifndef LORENTZIAN_PEAK_PRODUCT_TOP_MACROS_SVH
`define LORENTZIAN_PEAK_PRODUCT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpp_pkg;

  // Default number of fraction bits of one factor and of the running product.
  localparam int FACTOR_FRAC_BITS_DEF = 16;

  // Field widths of the item channels.
  localparam int WIDTH_W  = 16;
  localparam int CENTER_W = 24;
  localparam int POINT_W  = 16;
  localparam int HEIGHT_W = 32;
  localparam int PEAK_W   = 32;

  // Internal widths: |point - center| in Q.8, numerator and denominator in Q.16.
  localparam int DIFF_W = 24;
  localparam int NUM_W  = 32;
  localparam int DEN_W  = 49;

  // Register port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_RATIO_MODE = 1'b0;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

endpackage

`default_nettype wire

// ----- design/lpp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that yields one quotient bit per cycle, most significant
// first, and folds each bit straight into the product by shift and add.
module lpp_div
  import lpp_pkg::*;
#(
  parameter int FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_W-1:0]     num,
  input  wire logic [DEN_W-1:0]     den,
  input  wire logic [FRAC_BITS:0]   prod_in,
  output ser_sts_t                  sts,
  output logic      [FRAC_BITS:0]   prod_out
);

  localparam int PROD_W = FRAC_BITS + 1;
  localparam int ACC_W  = 2 * PROD_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(FRAC_BITS);

  logic              busy_r;
  logic              done_r;
  logic              first_r;
  logic              nz_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] mcand_r;
  logic [ACC_W-1:0]  acc_r;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic              qbit;
  logic [DEN_W-1:0]  rem_nxt;
  logic [ACC_W-1:0]  acc_nxt;

  // One division step: the first step compares the numerator itself, later
  // steps the doubled remainder. A zero numerator keeps every quotient bit out of the product.
  always_comb begin
    rem_sh   = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    rem_diff = rem_sh - {1'b0, den_r};
    qbit     = (rem_sh >= {1'b0, den_r});
    rem_nxt  = qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} + ((qbit && nz_r) ? ACC_W'(mcand_r) : '0);
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CNT_FIRST;
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      nz_r    <= (num != '0);
      rem_r   <= DEN_W'(num);
      den_r   <= den;
      mcand_r <= prod_in;
      acc_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod_out = acc_r[ACC_W-2:FRAC_BITS];

endmodule

`default_nettype wire

// ----- design/lpp_hmul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial multiplier for height times product, one product bit per cycle,
// most significant bit first.
module lpp_hmul
  import lpp_pkg::*;
#(
  parameter int FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [HEIGHT_W-1:0]  height,
  input  wire logic [FRAC_BITS:0]   prod_in,
  output ser_sts_t                  sts,
  output logic      [PEAK_W-1:0]    peak
);

  localparam int PROD_W = FRAC_BITS + 1;
  localparam int ACC_W  = HEIGHT_W + PROD_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(FRAC_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   mplr_r;
  logic [HEIGHT_W-1:0] h_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;

  // Double the partial sum and add the height where the product bit is set.
  always_comb begin
    acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (mplr_r[PROD_W-1] ? ACC_W'(h_r) : '0);
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_FIRST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Multiplier shift register and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      mplr_r <= prod_in;
      h_r    <= height;
      acc_r  <= '0;
    end else if (busy_r) begin
      mplr_r <= {mplr_r[PROD_W-2:0], 1'b0};
      acc_r  <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign peak     = acc_r[FRAC_BITS+PEAK_W-1:FRAC_BITS];

endmodule

`default_nettype wire

// ----- design/lorentzian_peak_product_top.sv -----
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_width, in_center, in_point, in_height, in_last_dim
// result    out_valid / out_ready   out_peak_value
// register  psel/penable/pwrite     paddr, pwdata, prdata, pready (always high)
//
// One item at a time: after a non-last item the next one is accepted once the sequencer has
// gone through S_DIFF, S_SQR and the bit-serial divider in S_DIV and is back in S_IDLE.
// A last-dimension item also waits for the serial height multiply and the output load.
// Reset is synchronous and active low; it sets the running product to one and ratio_mode
// to 0, and holds in_ready low. A stalled result waits in the output register; a finished
// last item waits for that register before the next item.
`timescale 1ns / 1ps
`default_nettype none
`include "lorentzian_peak_product_top_macros.svh"

module lorentzian_peak_product_top
  import lpp_pkg::*;
#(
  parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [WIDTH_W-1:0]    in_width,
  input  wire logic [CENTER_W-1:0]   in_center,
  input  wire logic [POINT_W-1:0]    in_point,
  input  wire logic [HEIGHT_W-1:0]   in_height,
  input  wire logic                  in_last_dim,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PEAK_W-1:0]     out_peak_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int PROD_W = FACTOR_FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] UNIT = {1'b1, {FACTOR_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SQR,
    S_DIV,
    S_HMUL,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PEAK_W-1:0]   out_peak_r, out_peak_nxt;
  logic [PROD_W-1:0]   product_r, product_nxt;
  logic                ratio_mode_r;

  logic [WIDTH_W-1:0]  w_r;
  logic [CENTER_W-1:0] c_r;
  logic [POINT_W-1:0]  p_r;
  logic [HEIGHT_W-1:0] h_r;
  logic                last_r;
  logic [DIFF_W-1:0]   ad_r;
  logic [NUM_W-1:0]    num_r;

  logic [DIFF_W-1:0]   p8;
  logic [NUM_W-1:0]    num_calc;
  logic [DEN_W-1:0]    den_calc;
  logic                in_fire;
  logic                cfg_wr;
  logic                div_start;
  logic                hmul_start;
  ser_sts_t            div_sts;
  ser_sts_t            hmul_sts;
  logic [PROD_W-1:0]   div_prod;
  logic [PEAK_W-1:0]   hmul_peak;

  assign in_fire = in_valid && in_ready;
  assign p8      = {p_r, 8'b0};

  // Register port: writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_mode_r <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_RATIO_MODE)) begin
      ratio_mode_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RATIO_MODE) begin
      prdata = CFG_DATA_W'(ratio_mode_r);
    end
  end

  // Numerator and distance, then denominator from the squared distance.
  always_comb begin
    num_calc = ratio_mode_r ? NUM_W'({w_r, 8'b0}) : NUM_W'(w_r * w_r);
    den_calc = DEN_W'(num_r) + DEN_W'(ad_r * ad_r);
  end

  // Captured item fields and first arithmetic stage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r    <= in_width;
      c_r    <= in_center;
      p_r    <= in_point;
      h_r    <= in_height;
      last_r <= in_last_dim;
    end
    if (state_r == S_DIFF) begin
      ad_r  <= (p8 >= c_r) ? (p8 - c_r) : (c_r - p8);
      num_r <= num_calc;
    end
  end

  assign div_start  = (state_r == S_SQR);
  assign hmul_start = (state_r == S_DIV) && div_sts.done && last_r;

  lpp_div #(
    .FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (num_r),
    .den      (den_calc),
    .prod_in  (product_r),
    .sts      (div_sts),
    .prod_out (div_prod)
  );

  lpp_hmul #(
    .FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_hmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hmul_start),
    .height  (h_r),
    .prod_in (div_prod),
    .sts     (hmul_sts),
    .peak    (hmul_peak)
  );

  // Sequencer, running product and output register.
  always_comb begin
    state_nxt     = state_r;
    product_nxt   = product_r;
    out_valid_nxt = out_valid_r;
    out_peak_nxt  = out_peak_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        state_nxt = S_SQR;
      end
      S_SQR: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (last_r) begin
            // The multiplier has taken the product; start the next evaluation at one.
            product_nxt = UNIT;
            state_nxt   = S_HMUL;
          end else begin
            product_nxt = div_prod;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_HMUL: begin
        if (hmul_sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_peak_nxt  = hmul_peak;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      product_r   <= UNIT;
      out_valid_r <= 1'b0;
      out_peak_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      product_r   <= product_nxt;
      out_valid_r <= out_valid_nxt;
      out_peak_r  <= out_peak_nxt;
    end
  end

  // No item is taken while reset is held.
  assign in_ready       = (state_r == S_IDLE) && rst_n;
  assign out_valid      = out_valid_r;
  assign out_peak_value = out_peak_r;

  // Checks on the sequencing of the two serial units and on the running product.
  `LPP_ASSERT_NOW(a_div_done_state, div_sts.done, state_r == S_DIV, "divider done out of state")
  `LPP_ASSERT_NOW(a_hmul_done_state, hmul_sts.done, state_r == S_HMUL, "multiplier done out of state")
  `LPP_ASSERT_NOW(a_units_exclusive, div_sts.busy, !hmul_sts.busy, "serial units overlap")
  `LPP_ASSERT_NOW(a_product_range, 1'b1, product_r <= UNIT, "running product above one")
  `LPP_ASSERT_NEXT(a_last_resets_product, hmul_start, product_r == UNIT, "product not set to one")

endmodule

`default_nettype wire
